// ----- design/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants and types for the nearest point search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int MAX_POINTS_DEF  = 1024;
  localparam int COORD_WIDTH_DEF = 24;

  localparam int NUM_PTS_W = 11;   // num_points register
  localparam int PIDX_W    = 10;   // point_index / nearest_index fields
  localparam int DIST_W    = 52;   // nearest_sq_distance field

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int OUT_DATA_W = ((PIDX_W + DIST_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - PIDX_W - DIST_W;

  // request kind carried on in_tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_en;     // store the input point
    logic start;     // latch query point, clear running minimum
    logic rd_en;     // read one table entry into the pipeline
    logic load_out;  // move the final minimum into the output register
  } nps_cmd_t;

endpackage : nps_pkg

`default_nettype wire

// ----- design/nps_ctrl.sv -----
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: handshakes, num_points register, scan counter and sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_ctrl #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic                         in_mode,
  input  wire logic                         cfg_tvalid,
  output logic                              cfg_tready,
  input  wire logic [nps_pkg::NUM_PTS_W-1:0] cfg_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output nps_pkg::nps_cmd_t                 cmd,
  output logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
  input  wire logic                         pipe_busy
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > NUM_PTS_W) ? CNT_W : NUM_PTS_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [NUM_PTS_W-1:0] num_points_r, num_points_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CMP_W-1:0]     scan_lim;
  logic                 in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign rd_addr    = cnt_r[IDX_W-1:0];

  // counts above the table depth scan the whole table
  assign scan_lim = (CMP_W'(num_points_r) > CMP_W'(MAX_POINTS)) ?
                    CMP_W'(MAX_POINTS) : CMP_W'(num_points_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    num_points_nxt = num_points_r;
    out_valid_nxt  = out_valid_r;
    cmd            = '0;

    if (cfg_tvalid && cfg_tready) begin
      num_points_nxt = cfg_tdata;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_WRITE)) begin
          cmd.wr_en = 1'b1;
        end else if (in_acc) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (CMP_W'(cnt_r) < scan_lim) begin
          cmd.rd_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for a free output slot
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_points_r <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_points_r <= num_points_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule : nps_ctrl

`default_nettype wire

// ----- design/nps_datapath.sv -----
// ----------------------------------------------------------------------------
// nps_datapath
// Point tables, distance pipeline and running first-minimum tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_datapath #(
  parameter int MAX_POINTS  = nps_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire nps_pkg::nps_cmd_t             cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  wire logic [nps_pkg::PIDX_W-1:0]    in_point_index,
  input  wire logic [COORD_WIDTH-1:0]        in_coord_x,
  input  wire logic [COORD_WIDTH-1:0]        in_coord_y,
  output logic                               pipe_busy,
  output logic                               out_found,
  output logic [nps_pkg::PIDX_W-1:0]         out_index,
  output logic [nps_pkg::DIST_W-1:0]         out_dist
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CW    = COORD_WIDTH;

  logic [CW-1:0] mem_x [MAX_POINTS];
  logic [CW-1:0] mem_y [MAX_POINTS];

  logic              wr_ok;
  logic [IDX_W-1:0]  wr_addr;

  // query point
  logic [CW-1:0]     qx_r, qy_r;

  // stage 1: table read
  logic              v1_r;
  logic [IDX_W-1:0]  idx1_r;
  logic [CW-1:0]     px_r, py_r;

  // stage 2: absolute differences
  logic [CW:0]       diff_x, diff_y, neg_x, neg_y;
  logic [CW-1:0]     dx_nxt, dy_nxt;
  logic              v2_r;
  logic [IDX_W-1:0]  idx2_r;
  logic [CW-1:0]     dx_r, dy_r;

  // stage 3: squares
  logic              v3_r;
  logic [IDX_W-1:0]  idx3_r;
  logic [2*CW-1:0]   sqx_r, sqy_r;

  // stage 4: saturated sum
  logic [2*CW:0]     sum;
  logic [63:0]       sum_ext;
  logic [DIST_W-1:0] dist_nxt;
  logic              v4_r;
  logic [IDX_W-1:0]  idx4_r;
  logic [DIST_W-1:0] dist_r;

  // running minimum
  logic              best_found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic              take;

  logic              out_found_r;
  logic [PIDX_W-1:0] out_index_r;
  logic [DIST_W-1:0] out_dist_r;

  assign wr_ok   = (32'(in_point_index) < MAX_POINTS);
  assign wr_addr = IDX_W'(in_point_index);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem_x[wr_addr] <= in_coord_x;
      mem_y[wr_addr] <= in_coord_y;
    end
    if (cmd.rd_en) begin
      px_r <= mem_x[rd_addr];
      py_r <= mem_y[rd_addr];
    end
  end

  assign diff_x = {qx_r[CW-1], qx_r} - {px_r[CW-1], px_r};
  assign diff_y = {qy_r[CW-1], qy_r} - {py_r[CW-1], py_r};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  // |diff| stays below 2^CW, so CW bits hold it
  assign dx_nxt = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
  assign dy_nxt = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

  assign sum      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign sum_ext  = 64'(sum);
  assign dist_nxt = (sum_ext > 64'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];

  assign take = v4_r && (!best_found_r || (dist_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
    end
    idx1_r <= rd_addr;
    idx2_r <= idx1_r;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    idx3_r <= idx2_r;
    sqx_r  <= dx_r * dx_r;
    sqy_r  <= dy_r * dy_r;
    idx4_r <= idx3_r;
    dist_r <= dist_nxt;
    if (cmd.start) begin
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (take) begin
      best_idx_r  <= idx4_r;
      best_dist_r <= dist_r;
    end
    if (cmd.load_out) begin
      out_index_r <= PIDX_W'(best_idx_r);
      out_dist_r  <= best_dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      best_found_r <= 1'b0;
      out_found_r  <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.start) begin
        best_found_r <= 1'b0;
      end else if (take) begin
        best_found_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_found_r <= best_found_r;
      end
    end
  end

  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign out_found = out_found_r;
  assign out_index = out_index_r;
  assign out_dist  = out_dist_r;

endmodule : nps_datapath

`default_nettype wire

// ----- design/nearest_point_search_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// Brute force 2D nearest point search over a table of Q16.8 points.
// ----------------------------------------------------------------------------
// in_*  : one request per handshake, in_tuser = mode (0 write, 1 query).
//         A write stores (coord_x, coord_y) at point_index and gives no
//         result; slots at or above MAX_POINTS are dropped.
// cfg_* : sets num_points, the number of slots a query scans (always ready).
// out_* : one result per query: tuser found, tdata index and squared
//         distance. An empty scan returns found = 0 with zero fields.
// Sequence: after a query's accept, N = min(num_points, MAX_POINTS) slots
//   are read one per cycle into a four-stage distance pipeline, which then
//   drains before the result loads into the output register.
// Flow: one request in work at a time; in_tready is low from a query's
//   accept until its result loads.
// Reset: num_points clears to 0 and the output empties; the table is not
//   cleared (slots read before written return arbitrary data).
// Stall: a result waits in the output register until taken; requests are
//   still accepted, and a finished query waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_unit #(
  parameter int  MAX_POINTS  = nps_pkg::MAX_POINTS_DEF,
  parameter int  COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF,
  localparam int IN_DATA_W   = ((nps_pkg::PIDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [IN_DATA_W-1:0]            in_tdata,   // point_index, coord_x, coord_y
  input  wire logic                            in_tuser,   // mode
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [nps_pkg::OUT_DATA_W-1:0]       out_tdata,  // nearest_index, nearest_sq_distance
  output logic                                 out_tuser,  // found
  input  wire logic                            cfg_tvalid,
  output logic                                 cfg_tready,
  input  wire logic [nps_pkg::NUM_PTS_W-1:0]   cfg_tdata   // num_points
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  nps_cmd_t          cmd;
  logic [IDX_W-1:0]  rd_addr;
  logic              pipe_busy;
  logic              res_found;
  logic [PIDX_W-1:0] res_index;
  logic [DIST_W-1:0] res_dist;

  nps_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .pipe_busy  (pipe_busy)
  );

  nps_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .in_point_index (in_tdata[PIDX_W-1:0]),
    .in_coord_x     (in_tdata[PIDX_W +: COORD_WIDTH]),
    .in_coord_y     (in_tdata[PIDX_W + COORD_WIDTH +: COORD_WIDTH]),
    .pipe_busy      (pipe_busy),
    .out_found      (res_found),
    .out_index      (res_index),
    .out_dist       (res_dist)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_dist, res_index};
  assign out_tuser = res_found;

endmodule : nearest_point_search_unit

`default_nettype wire

// ----- design/nps_checker.sv -----
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for the nearest point search unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          in_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [nps_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tuser
);
  import nps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // empty scan reports all zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty result carries nonzero data");

  // a query blocks further requests while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_QUERY) |=> !in_tready)
    else $error("request accepted during scan");

  // a write completes in its accept cycle
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_WRITE) |=> in_tready)
    else $error("write request stalled the input");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule : nps_checker

bind nearest_point_search_unit nps_checker u_nps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
